// ===== src/deadline_sorted_timer_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Timer queue assertion macros
// Shared concurrent assertion helpers for the timer queue modules.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_SORTED_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication
`define DSTQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DSTQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dstq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer queue package
// Sizes, request/result types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dstq_pkg;

  localparam int SLOTS     = 16;
  localparam int MAX_FIRES = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int FIRE_W    = $clog2(MAX_FIRES + 1);
  localparam logic [30:0] DEC_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_RUN   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_START = 2'd2,
    MODE_STOP  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  slot;
    logic [63:0] now;
    logic [63:0] delay;
    logic [63:0] reload;
  } req_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_slot;
    logic        dec_write;
    logic [30:0] dec_value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic  capture;
    logic  set_mode;
    mode_e mode;
    logic  fires_clr;
    logic  rd_head;
    logic  rd_pos;
    logic  start_arm;
    logic  stop_do;
    logic  fire;
    logic  pos_inc;
    logic  ins_do;
    logic  emit_last;
    logic  last_write;
  } cmd_t;

  typedef struct packed {
    logic is_run;
    logic is_start;
    logic is_stop;
    logic slot_ok;
    logic slot_armed;
    logic list_empty;
    logic fire_limit;
    logic due;
    logic iv_nz;
    logic advance;
    logic dw;
  } sts_t;

endpackage

// ===== src/dstq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Timer queue controller
// Sequences start, stop and run requests over the datapath.
// ----------------------------------------------------------------------------
`include "deadline_sorted_timer_queue_defines.svh"

module dstq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dstq_pkg::sts_t sts_i,
  output dstq_pkg::cmd_t cmd_o
);
  import dstq_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_DECODE  = 10'b00_0000_0010,
    ST_START   = 10'b00_0000_0100,
    ST_STOP    = 10'b00_0000_1000,
    ST_RUN_RD  = 10'b00_0001_0000,
    ST_RUN_CHK = 10'b00_0010_0000,
    ST_INS_RD  = 10'b00_0100_0000,
    ST_INS_CMP = 10'b00_1000_0000,
    ST_FIN     = 10'b01_0000_0000,
    ST_DEC_OUT = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.set_mode  = 1'b1;
        cmd_o.fires_clr = 1'b1;
        if (sts_i.is_run) begin
          cmd_o.mode = MODE_RUN;
          state_d = ST_RUN_RD;
        end else if (sts_i.is_start && sts_i.slot_ok) begin
          cmd_o.mode = MODE_START;
          state_d = ST_START;
        end else if (sts_i.is_stop && sts_i.slot_ok && sts_i.slot_armed) begin
          cmd_o.mode = MODE_STOP;
          state_d = ST_STOP;
        end else begin
          cmd_o.mode = MODE_NONE;
          state_d = ST_FIN;
        end
      end
      ST_START: begin
        cmd_o.start_arm = 1'b1;
        state_d = ST_INS_RD;
      end
      ST_STOP: begin
        cmd_o.stop_do = 1'b1;
        state_d = ST_FIN;
      end
      ST_RUN_RD: begin
        if (sts_i.list_empty || sts_i.fire_limit) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d = ST_RUN_CHK;
        end
      end
      ST_RUN_CHK: begin
        if (!sts_i.due) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.fire = 1'b1;
          state_d = sts_i.iv_nz ? ST_INS_RD : ST_RUN_RD;
        end
      end
      ST_INS_RD: begin
        cmd_o.rd_pos = 1'b1;
        state_d = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (sts_i.advance) begin
          cmd_o.pos_inc = 1'b1;
          state_d = ST_INS_RD;
        end else begin
          cmd_o.ins_do = 1'b1;
          state_d = sts_i.is_run ? ST_RUN_RD : ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.dw) begin
          cmd_o.rd_head = 1'b1;
          state_d = ST_DEC_OUT;
        end else begin
          cmd_o.emit_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DEC_OUT: begin
        cmd_o.emit_last  = 1'b1;
        cmd_o.last_write = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DSTQ_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "accept not busy")
  `DSTQ_ASSERT_IMP(a_ins_no_accept, clk_i, rst_ni, cmd_o.ins_do || cmd_o.fire, busy_o, "idle update")
  `DSTQ_ASSERT_NXT(a_last_idle, clk_i, rst_ni, cmd_o.emit_last, !busy_o, "last not at end")

endmodule

// ===== src/dstq_dp.sv =====
// ----------------------------------------------------------------------------
// Timer queue datapath
// Slot memories, ordered slot list, compare logic and result register.
// ----------------------------------------------------------------------------
`include "deadline_sorted_timer_queue_defines.svh"

module dstq_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dstq_pkg::req_t req_i,
  input  dstq_pkg::cmd_t cmd_i,
  output dstq_pkg::sts_t sts_o,
  output logic           res_valid_o,
  output dstq_pkg::res_t res_o
);
  import dstq_pkg::*;

  logic [63:0] dl_mem [SLOTS];
  logic [63:0] iv_mem [SLOTS];

  req_t              req_q;
  logic [SLOT_W-1:0] order_q [SLOTS];
  logic [CNT_W-1:0]  count_q;
  logic [SLOTS-1:0]  armed_q;
  logic [CNT_W-1:0]  pos_q;
  logic [FIRE_W-1:0] fires_q;
  logic [63:0]       new_dl_q;
  logic [SLOT_W-1:0] cur_q;
  logic              had_q;
  logic [SLOT_W-1:0] old_q;
  logic              was_head_q;
  mode_e             mode_q;
  logic [63:0]       rd_dl_q;
  logic [63:0]       rd_iv_q;
  logic              res_valid_q;
  res_t              res_q;
  res_t              res_d;

  logic [SLOT_W-1:0] s_idx;
  logic [SLOT_W-1:0] pos_idx;
  logic [SLOT_W-1:0] rd_addr;
  logic              rd_en;
  logic [SLOT_W-1:0] rm_slot;
  logic              rm_en;
  logic [SLOTS-1:0]  ge;
  logic              rm_hit;
  logic              dl_we;
  logic [SLOT_W-1:0] dl_waddr;
  logic [63:0]       dl_wdata;
  logic [63:0]       dec_diff;
  logic [30:0]       dec_val;
  logic              dw;

  function automatic logic is_before(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = b - a;
    return (d != 64'd0) && !d[63];
  endfunction

  assign s_idx   = SLOT_W'(req_q.slot);
  assign pos_idx = pos_q[SLOT_W-1:0];
  assign rd_en   = cmd_i.rd_head | cmd_i.rd_pos;
  assign rd_addr = cmd_i.rd_head ? order_q[0] : order_q[pos_idx];

  assign rm_slot = cmd_i.fire ? order_q[0] : s_idx;
  assign rm_en   = cmd_i.fire | cmd_i.stop_do | (cmd_i.start_arm & armed_q[s_idx]);

  // ge[i]: the removed entry sits at or below position i
  always_comb begin
    logic run;
    run = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      run = run | ((order_q[i] == rm_slot) && (CNT_W'(i) < count_q));
      ge[i] = run;
    end
    rm_hit = run;
  end

  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = s_idx;
    dl_wdata = req_q.now + req_q.delay;
    if (cmd_i.start_arm) begin
      dl_we = 1'b1;
    end else if (cmd_i.fire && (rd_iv_q != 64'd0)) begin
      dl_we    = 1'b1;
      dl_waddr = order_q[0];
      dl_wdata = rd_dl_q + rd_iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    if (cmd_i.start_arm) begin
      iv_mem[s_idx] <= req_q.reload;
    end
    if (rd_en) begin
      rd_dl_q <= dl_mem[rd_addr];
      rd_iv_q <= iv_mem[rd_addr];
    end
  end

  assign dec_diff = rd_dl_q - req_q.now;
  always_comb begin
    if (dec_diff[63]) begin
      dec_val = 31'd0;
    end else if (dec_diff[62:31] != 32'd0) begin
      dec_val = DEC_MAX;
    end else begin
      dec_val = dec_diff[30:0];
    end
  end

  always_comb begin
    case (mode_q)
      MODE_RUN:   dw = (count_q != '0);
      MODE_START: dw = !had_q || (order_q[0] != old_q);
      MODE_STOP:  dw = was_head_q && (count_q != '0);
      default:    dw = 1'b0;
    endcase
  end

  always_comb begin
    sts_o            = '0;
    sts_o.is_run     = (req_q.func == FUNC_RUN);
    sts_o.is_start   = (req_q.func == FUNC_START);
    sts_o.is_stop    = (req_q.func == FUNC_STOP);
    sts_o.slot_ok    = ({1'b0, req_q.slot} < 5'(SLOTS));
    sts_o.slot_armed = armed_q[s_idx];
    sts_o.list_empty = (count_q == '0);
    sts_o.fire_limit = (fires_q == FIRE_W'(MAX_FIRES));
    sts_o.due        = !is_before(req_q.now, rd_dl_q);
    sts_o.iv_nz      = (rd_iv_q != 64'd0);
    sts_o.advance    = (pos_q < count_q) && is_before(rd_dl_q, new_dl_q);
    sts_o.dw         = dw;
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.emit_last) begin
      res_d           = '0;
      res_d.last      = 1'b1;
      res_d.dec_write = cmd_i.last_write;
      res_d.dec_value = cmd_i.last_write ? dec_val : 31'd0;
    end else if (cmd_i.fire) begin
      res_d            = '0;
      res_d.fired      = 1'b1;
      res_d.fired_slot = 4'(order_q[0]);
    end
  end

  // payload-only registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.start_arm) begin
      new_dl_q <= dl_wdata;
      cur_q    <= s_idx;
      had_q    <= (count_q != '0);
      old_q    <= order_q[0];
    end
    if (cmd_i.fire) begin
      new_dl_q <= dl_wdata;
      cur_q    <= order_q[0];
    end
    if (cmd_i.stop_do) begin
      was_head_q <= (order_q[0] == s_idx);
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      armed_q     <= '0;
      pos_q       <= '0;
      fires_q     <= '0;
      mode_q      <= MODE_NONE;
      res_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        order_q[i] <= '0;
      end
    end else begin
      res_valid_q <= cmd_i.emit_last | cmd_i.fire;
      if (cmd_i.set_mode) begin
        mode_q <= cmd_i.mode;
      end
      if (cmd_i.fires_clr) begin
        fires_q <= '0;
      end else if (cmd_i.fire) begin
        fires_q <= fires_q + FIRE_W'(1);
      end
      if (cmd_i.start_arm || cmd_i.fire) begin
        pos_q <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + CNT_W'(1);
      end
      if (cmd_i.start_arm) begin
        armed_q[s_idx] <= 1'b1;
      end else if (cmd_i.stop_do) begin
        armed_q[s_idx] <= 1'b0;
      end else if (cmd_i.fire && (rd_iv_q == 64'd0)) begin
        armed_q[order_q[0]] <= 1'b0;
      end
      if (rm_en && rm_hit) begin
        for (int i = 0; i < SLOTS - 1; i++) begin
          if (ge[i]) begin
            order_q[i] <= order_q[i+1];
          end
        end
        count_q <= count_q - CNT_W'(1);
      end else if (cmd_i.ins_do) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (SLOT_W'(i) == pos_idx) begin
            order_q[i] <= cur_q;
          end else if ((i > 0) && (SLOT_W'(i) > pos_idx)) begin
            order_q[i] <= order_q[(i > 0) ? i - 1 : 0];
          end
        end
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `DSTQ_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(SLOTS), "count overflow")
  `DSTQ_ASSERT_IMP(a_armed_count, clk_i, rst_ni, !cmd_i.ins_do && !cmd_i.pos_inc && !cmd_i.rd_pos && !cmd_i.start_arm && !cmd_i.fire, $countones(armed_q) == int'(count_q), "armed/queued mismatch")
  `DSTQ_ASSERT_NXT(a_fire_strobe, clk_i, rst_ni, cmd_i.fire, res_valid_o && res_o.fired, "fire lost")

endmodule

// ===== src/deadline_sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Deadline-sorted timer queue
// Up to SLOTS timers kept in wrap-safe deadline order, with start, stop and
// run requests and decrementer reprogramming.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start; the request is taken on a clock edge
// where start is high and busy is low. busy stays high until the request is
// finished. Results appear on res_o for one cycle each, marked by
// res_valid_o; the receiver cannot hold them off. A run request gives one
// result per fired slot and every request ends with one result that has
// last set and carries any decrementer write.
// Steps from accept to the last result: a start walks the list to its insert
// point, each entry taking a registered deadline read and then a compare; a
// run fires due heads in turn and walks the list again for each periodic
// fire; a decrementer write adds a registered head read before the last
// result. The next request can be taken in the cycle its last result is
// shown.
// Reset clears the list, the armed flags and the controller; slot deadline
// and period memories hold garbage until a slot is started.
// ----------------------------------------------------------------------------
module deadline_sorted_timer_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dstq_pkg::req_t req_i,
  output logic           res_valid_o,
  output dstq_pkg::res_t res_o
);
  import dstq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dstq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  dstq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Timer queue testbench
// Sends start, stop and run requests in bursts, predicts each request's
// fires and decrementer writes from a behavioral copy of the ordered list
// and checks every result in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dstq_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_REQS = 500;

  typedef struct {
    req_t req;
    logic typed;
    res_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic res_valid_o;
  res_t res_o;

  deadline_sorted_timer_queue dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the timer list
  logic [63:0] slot_deadline [SLOTS];
  logic [63:0] slot_period [SLOTS];
  logic        slot_armed [SLOTS];
  logic [3:0]  deadline_order [$];
  res_t        pending_res [$];
  int          mismatches = 0;
  int          cycles = 0;
  row_t        directed [$];
  logic [63:0] tick = 64'd1000;

  function automatic logic earlier(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = b - a;
    return d != 64'd0 && !d[63];
  endfunction

  function automatic void list_insert(logic [3:0] s);
    int pos;
    pos = 0;
    while (pos < deadline_order.size() &&
           earlier(slot_deadline[deadline_order[pos]], slot_deadline[s]))
      pos++;
    deadline_order.insert(pos, s);
  endfunction

  function automatic void list_remove(logic [3:0] s);
    foreach (deadline_order[i])
      if (deadline_order[i] == s) begin
        deadline_order.delete(i);
        return;
      end
  endfunction

  function automatic logic [30:0] head_countdown(logic [63:0] now);
    logic [63:0] d;
    d = slot_deadline[deadline_order[0]] - now;
    if (d[63]) return 31'd0;
    if (d > {33'd0, DEC_MAX}) return DEC_MAX;
    return d[30:0];
  endfunction

  // returns the results of one request, closing result last
  function automatic void predict_timers(req_t r, ref res_t outs[$]);
    logic dw;
    logic had;
    logic [3:0] old_head, cur;
    int fires;
    res_t x;
    dw = 1'b0;
    outs.delete();
    case (func_e'(r.func))
      FUNC_RUN: begin
        fires = 0;
        while (deadline_order.size() > 0 && fires < MAX_FIRES &&
               !earlier(r.now, slot_deadline[deadline_order[0]])) begin
          cur = deadline_order[0];
          list_remove(cur);
          if (slot_period[cur] != 64'd0) begin
            slot_deadline[cur] += slot_period[cur];
            list_insert(cur);
          end else begin
            slot_armed[cur] = 1'b0;
          end
          x = '0;
          x.fired = 1'b1;
          x.fired_slot = cur;
          outs.push_back(x);
          fires++;
        end
        dw = deadline_order.size() > 0;
      end
      FUNC_START: begin
        had = deadline_order.size() > 0;
        old_head = had ? deadline_order[0] : 4'd0;
        if (slot_armed[r.slot]) list_remove(r.slot);
        slot_deadline[r.slot] = r.now + r.delay;
        slot_period[r.slot] = r.reload;
        slot_armed[r.slot] = 1'b1;
        list_insert(r.slot);
        dw = !had || deadline_order[0] != old_head;
      end
      FUNC_STOP: begin
        if (slot_armed[r.slot]) begin
          had = deadline_order.size() > 0 && deadline_order[0] == r.slot;
          list_remove(r.slot);
          slot_armed[r.slot] = 1'b0;
          dw = had && deadline_order.size() > 0;
        end
      end
      default: ;
    endcase
    x = '0;
    x.last = 1'b1;
    if (dw) begin
      x.dec_write = 1'b1;
      x.dec_value = head_countdown(r.now);
    end
    outs.push_back(x);
  endfunction

  function automatic req_t mk(func_e f, logic [3:0] s, logic [63:0] now,
                              logic [63:0] dly, logic [63:0] rl);
    req_t r;
    r.func = f; r.slot = s; r.now = now; r.delay = dly; r.reload = rl;
    return r;
  endfunction

  function automatic void add_row(req_t r, logic typed, res_t e);
    row_t w;
    w.req = r; w.typed = typed; w.res = e;
    directed.push_back(w);
  endfunction

  function automatic res_t closing(logic dw, logic [30:0] v);
    res_t e;
    e = '0; e.last = 1'b1; e.dec_write = dw; e.dec_value = v;
    return e;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int k;
    k = $urandom_range(99);
    r.slot = 4'($urandom_range(15));
    tick += 64'($urandom_range(40));
    r.now = ($urandom_range(19) == 0) ? {$urandom, $urandom} : tick;
    r.delay = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(300));
    case ($urandom_range(3))
      0, 1: r.reload = 64'd0;
      2: r.reload = 64'($urandom_range(1, 120));
      default: r.reload = {$urandom, $urandom};
    endcase
    if (k < 45) r.func = FUNC_START;
    else if (k < 60) r.func = FUNC_STOP;
    else if (k < 97) r.func = FUNC_RUN;
    else r.func = FUNC_NONE;
    return r;
  endfunction

  task automatic send(req_t r, logic typed, res_t e);
    res_t outs [$];
    req_i <= r;
    start <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_timers(r, outs);
    if (typed) outs[outs.size() - 1] = e;
    foreach (outs[i]) pending_res.push_back(outs[i]);
    @(negedge clk_i);
  endtask

  // burst pacing: start stays high within a burst, drops between most bursts
  int burst_left = 0;
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(3) != 0) begin
        start <= 1'b0;
        gap = $urandom_range(1, 6);
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  initial begin
    req_t r;
    foreach (slot_armed[i]) begin
      slot_armed[i] = 1'b0;
      slot_deadline[i] = '0;
      slot_period[i] = '0;
    end
    // empty list, unarmed stop, undefined function
    add_row(mk(FUNC_RUN, 4'd0, 64'd0, 64'd0, 64'd0), 1'b1, closing(1'b0, 31'd0));
    add_row(mk(FUNC_STOP, 4'd15, '1, '1, '1), 1'b1, closing(1'b0, 31'd0));
    add_row(mk(FUNC_NONE, 4'd15, '1, '1, '1), 1'b1, closing(1'b0, 31'd0));
    // first start on empty list, clamp to max, zero countdown
    add_row(mk(FUNC_START, 4'd3, 64'd1000, 64'd100, 64'd0), 1'b1, closing(1'b1, 31'd100));
    add_row(mk(FUNC_STOP, 4'd3, 64'd1000, 64'd0, 64'd0), 1'b1, closing(1'b0, 31'd0));
    add_row(mk(FUNC_START, 4'd0, 64'd0, '1, '1), 1'b0, '0);
    add_row(mk(FUNC_STOP, 4'd0, 64'd0, 64'd0, 64'd0), 1'b1, closing(1'b0, 31'd0));
    add_row(mk(FUNC_START, 4'd1, 64'd5, 64'h1_0000_0000, 64'd0), 1'b1,
            closing(1'b1, DEC_MAX));
    add_row(mk(FUNC_START, 4'd2, '1, 64'd0, 64'd0), 1'b1, closing(1'b1, 31'd0));
    add_row(mk(FUNC_RUN, 4'd0, 64'd0, 64'd0, 64'd0), 1'b0, '0);
    // fill all slots with equal deadlines and short periods, then hit the fire limit
    for (int s = 0; s < SLOTS; s++)
      add_row(mk(FUNC_START, 4'(s), 64'd2000, 64'd10, 64'(1 + s % 3)), 1'b0, '0);
    add_row(mk(FUNC_RUN, 4'd0, 64'd2100, 64'd0, 64'd0), 1'b0, '0);
    add_row(mk(FUNC_RUN, 4'd0, 64'd2100, 64'd0, 64'd0), 1'b0, '0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) begin
      pace();
      send(directed[i].req, directed[i].typed, directed[i].res);
    end
    tick = 64'd3000;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pace();
      r = random_req();
      send(r, 1'b0, '0);
    end
    start <= 1'b0;
    while (pending_res.size() > 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (mismatches == 0) $display("deadline_sorted_timer_queue test passed");
    else $display("deadline_sorted_timer_queue test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        e = pending_res.pop_front();
        if (res_o.fired !== e.fired || res_o.fired_slot !== e.fired_slot ||
            res_o.dec_write !== e.dec_write || res_o.dec_value !== e.dec_value ||
            res_o.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p got %p", e, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("deadline_sorted_timer_queue test failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
+incdir+src
src/dstq_pkg.sv
src/dstq_ctrl.sv
src/dstq_dp.sv
src/deadline_sorted_timer_queue.sv
verif/testbench.sv
